@@ design/swbd_pkg.sv @@
// Shared types and constants for the sliding-window beat detector.
package swbd_pkg;

    // Fixed field widths
    localparam int ENERGY_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W     = 16;

    // Score is compared as 256 * d^2 against T2 * V (T2 in Q8.8)
    localparam int SCORE_SHIFT = 8;

    // Register reset values
    localparam logic [CFG_W-1:0] STRONG_THR_RESET  = 16'd576;
    localparam logic [CFG_W-1:0] WEAK_THR_RESET    = 16'd256;
    localparam logic [CFG_W-1:0] STRONG_COOL_RESET = 16'd20;
    localparam logic [CFG_W-1:0] WEAK_COOL_RESET   = 16'd5;

    // Saturation value of the elapsed-frame counters
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STRONG_THR  = 2'd0,
        REG_WEAK_THR    = 2'd1,
        REG_STRONG_COOL = 2'd2,
        REG_WEAK_COOL   = 2'd3
    } cfg_reg_t;

    // Sequencer states: one wait state per multiplication
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MQ,
        ST_MSS,
        ST_MNQ,
        ST_MNX,
        ST_MDD,
        ST_MTS,
        ST_MTW,
        ST_DONE
    } state_t;

endpackage

@@ design/swbd_ram.sv @@
// Generic single-port-write, registered-read RAM.
module swbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/swbd_mul.sv @@
// Shift-add multiplier that consumes one multiplier bit per cycle.
module swbd_mul #(
    parameter int A_W = 44,
    parameter int B_W = 22,
    parameter int P_W = 60
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] product
);

    logic [P_W-1:0] mcand_reg, mcand_next;
    logic [B_W-1:0] mplier_reg, mplier_next;
    logic [P_W-1:0] acc_reg, acc_next;

    // Load on start, then add and shift until the multiplier runs out of ones
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            mcand_next  = {{(P_W-A_W){1'b0}}, a};
            mplier_next = b;
            acc_next    = '0;
        end
        else if (mplier_reg != '0)
        begin
            acc_next    = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
        end
        else
        begin
            mplier_reg <= mplier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign done    = (mplier_reg == '0);
    assign product = acc_reg;

    // A new product is only started once the previous one has finished
    a_start_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> done)
        else $error("multiplier restarted while busy");

endmodule

@@ design/sliding_window_beat_detector.sv @@
// Top level of the sliding-window beat detector: sequencer, window state and divider.
//
// Usage: one energy sample per audio frame enters on the input channel
// (in_valid/in_stall); each sample yields exactly one result on the output
// channel (out_valid/out_stall): strong_beat, weak_beat and window_mean.
// Thresholds and cooldowns must be written through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Sequencing: a sample is worked out from its transfer to its result by the
// shared shift-add multiplier, which retires one multiplier bit per cycle over
// seven products per sample; the mean comes from a one-bit-per-cycle divider
// running alongside, which sets the floor on the time to a result. The next
// sample is taken only once the result of the last one is registered.
// Reset: window, sums and elapsed counters read as zero and the registers
// take their defaults; window entries not yet written since reset are read
// as zero through a wrap flag, so there is no clearing pass.
// Receiver stall: a result holds in the output register; one more sample is
// taken and worked out, and its result waits until the output frees up.
module sliding_window_beat_detector #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swbd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [swbd_pkg::ENERGY_W-1:0]       energy,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                strong_beat,
    output logic                                weak_beat,
    output logic [swbd_pkg::ENERGY_W-1:0]       window_mean
);

    localparam int EW     = swbd_pkg::ENERGY_W;
    localparam int CW     = swbd_pkg::CFG_W;
    localparam int KW     = swbd_pkg::COUNT_W;
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = EW + $clog2(WINDOW_DEPTH);
    localparam int SQ_W   = 2 * EW + $clog2(WINDOW_DEPTH);
    localparam int NB     = $clog2(WINDOW_DEPTH + 1);
    localparam int V_W    = 2 * SUM_W;
    localparam int LHS_W  = V_W + swbd_pkg::SCORE_SHIFT;
    localparam int P_W    = V_W + CW;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    // Sequencer
    swbd_pkg::state_t state_reg, state_next;

    // Configuration
    logic [CW-1:0] strong_thr_reg, strong_thr_next;
    logic [CW-1:0] weak_thr_reg, weak_thr_next;
    logic [CW-1:0] strong_cool_reg, strong_cool_next;
    logic [CW-1:0] weak_cool_reg, weak_cool_next;

    // Window state
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              wrapped_reg, wrapped_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]   sq_sum_reg, sq_sum_next;
    logic [KW-1:0]     strong_elapsed_reg, strong_elapsed_next;
    logic [KW-1:0]     weak_elapsed_reg, weak_elapsed_next;

    // Per-sample working registers
    logic [EW-1:0]    x_reg, x_next;
    logic             sub_reg, sub_next;
    logic [V_W-1:0]   ss_reg, ss_next;
    logic [V_W-1:0]   var_reg, var_next;
    logic             above_reg, above_next;
    logic [LHS_W-1:0] lhs_reg, lhs_next;
    logic             strong_hit_reg, strong_hit_next;
    logic             weak_hit_reg, weak_hit_next;

    // Mean divider
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [SUM_W-1:0]  div_quo_reg, div_quo_next;
    logic [NB-1:0]     div_rem_reg, div_rem_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic          strong_beat_reg, strong_beat_next;
    logic          weak_beat_reg, weak_beat_next;
    logic [EW-1:0] window_mean_reg, window_mean_next;

    // Control from the output decode
    logic           mul_start;
    logic [V_W-1:0] mul_a;
    logic [SUM_W-1:0] mul_b;
    logic           mul_done;
    logic [P_W-1:0] mul_p;
    logic           ram_we;
    logic           out_load;

    logic [EW-1:0]  ram_rdata;
    logic [EW-1:0]  old_val;
    logic           x_ge_old;
    logic [EW-1:0]  delta;
    logic [EW:0]    pair_sum;
    logic [SUM_W-1:0] sum_upd;
    logic [SUM_W-1:0] nx_val;
    logic [SUM_W-1:0] d_val;
    logic           div_done;
    logic           out_free;
    logic [NB:0]    div_trial;
    logic           div_ge;
    logic [KW-1:0]  strong_inc;
    logic [KW-1:0]  weak_inc;
    logic           strong_fire;
    logic           weak_fire;

    // Sample window memory, read at the current slot and rewritten there
    swbd_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (x_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Shared multiplier
    swbd_mul #(
        .A_W (V_W),
        .B_W (SUM_W),
        .P_W (P_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Evicted sample, window sum update and the Q delta factors
    assign old_val  = wrapped_reg ? ram_rdata : '0;
    assign x_ge_old = (x_reg >= old_val);
    assign delta    = x_ge_old ? (x_reg - old_val) : (old_val - x_reg);
    assign pair_sum = {1'b0, x_reg} + {1'b0, old_val};
    assign sum_upd  = sum_reg + SUM_W'(x_reg) - SUM_W'(old_val);

    // N*x and the deviation from the window sum
    assign nx_val = mul_p[SUM_W-1:0];
    assign d_val  = nx_val - sum_reg;

    // Divider step
    assign div_done  = (div_cnt_reg == '0);
    assign div_trial = {div_rem_reg, div_quo_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= (NB+1)'(WINDOW_DEPTH));

    // Cooldown checks
    assign strong_inc  = (strong_elapsed_reg == swbd_pkg::COUNT_MAX) ?
                         strong_elapsed_reg : strong_elapsed_reg + 1'b1;
    assign weak_inc    = (weak_elapsed_reg == swbd_pkg::COUNT_MAX) ?
                         weak_elapsed_reg : weak_elapsed_reg + 1'b1;
    assign strong_fire = strong_hit_reg && (strong_inc > strong_cool_reg);
    assign weak_fire   = weak_hit_reg && (weak_inc > weak_cool_reg);

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swbd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = swbd_pkg::ST_READ;
                end
            end
            swbd_pkg::ST_READ: state_next = swbd_pkg::ST_MQ;
            swbd_pkg::ST_MQ:   if (mul_done) state_next = swbd_pkg::ST_MSS;
            swbd_pkg::ST_MSS:  if (mul_done) state_next = swbd_pkg::ST_MNQ;
            swbd_pkg::ST_MNQ:  if (mul_done) state_next = swbd_pkg::ST_MNX;
            swbd_pkg::ST_MNX:  if (mul_done) state_next = swbd_pkg::ST_MDD;
            swbd_pkg::ST_MDD:  if (mul_done) state_next = swbd_pkg::ST_MTS;
            swbd_pkg::ST_MTS:  if (mul_done) state_next = swbd_pkg::ST_MTW;
            swbd_pkg::ST_MTW:  if (mul_done) state_next = swbd_pkg::ST_DONE;
            swbd_pkg::ST_DONE:
            begin
                if (div_done && out_free)
                begin
                    state_next = swbd_pkg::ST_IDLE;
                end
            end
            default: state_next = swbd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input stall, multiplier operands, RAM write, result load
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        in_stall  = 1'b1;
        unique case (state_reg)
            swbd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            swbd_pkg::ST_READ:
            begin
                ram_we    = 1'b1;
                mul_start = 1'b1;
                mul_a     = V_W'(pair_sum);
                mul_b     = SUM_W'(delta);
            end
            swbd_pkg::ST_MQ:
            begin
                mul_start = mul_done;
                mul_a     = V_W'(sum_reg);
                mul_b     = sum_reg;
            end
            swbd_pkg::ST_MSS:
            begin
                mul_start = mul_done;
                mul_a     = V_W'(sq_sum_reg);
                mul_b     = SUM_W'(WINDOW_DEPTH);
            end
            swbd_pkg::ST_MNQ:
            begin
                mul_start = mul_done;
                mul_a     = V_W'(x_reg);
                mul_b     = SUM_W'(WINDOW_DEPTH);
            end
            swbd_pkg::ST_MNX:
            begin
                mul_start = mul_done;
                mul_a     = V_W'(d_val);
                mul_b     = d_val;
            end
            swbd_pkg::ST_MDD:
            begin
                mul_start = mul_done;
                mul_a     = var_reg;
                mul_b     = SUM_W'(strong_thr_reg);
            end
            swbd_pkg::ST_MTS:
            begin
                mul_start = mul_done;
                mul_a     = var_reg;
                mul_b     = SUM_W'(weak_thr_reg);
            end
            swbd_pkg::ST_MTW:
            begin
            end
            swbd_pkg::ST_DONE:
            begin
                out_load = div_done && out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration writes
    always_comb
    begin
        strong_thr_next  = strong_thr_reg;
        weak_thr_next    = weak_thr_reg;
        strong_cool_next = strong_cool_reg;
        weak_cool_next   = weak_cool_reg;
        if (cfg_we)
        begin
            unique case (swbd_pkg::cfg_reg_t'(cfg_index))
                swbd_pkg::REG_STRONG_THR:  strong_thr_next  = cfg_wdata;
                swbd_pkg::REG_WEAK_THR:    weak_thr_next    = cfg_wdata;
                swbd_pkg::REG_STRONG_COOL: strong_cool_next = cfg_wdata;
                swbd_pkg::REG_WEAK_COOL:   weak_cool_next   = cfg_wdata;
            endcase
        end
    end

    // Datapath updates per state
    always_comb
    begin
        x_next          = x_reg;
        slot_next       = slot_reg;
        wrapped_next    = wrapped_reg;
        sum_next        = sum_reg;
        sq_sum_next     = sq_sum_reg;
        sub_next        = sub_reg;
        ss_next         = ss_reg;
        var_next        = var_reg;
        above_next      = above_reg;
        lhs_next        = lhs_reg;
        strong_hit_next = strong_hit_reg;
        weak_hit_next   = weak_hit_reg;

        unique case (state_reg)
            swbd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = energy;
                end
            end
            swbd_pkg::ST_READ:
            begin
                sum_next     = sum_upd;
                sub_next     = !x_ge_old;
                slot_next    = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                wrapped_next = wrapped_reg || (slot_reg == SLOT_LAST);
            end
            swbd_pkg::ST_MQ:
            begin
                // Q += (x - old) * (x + old), sign kept apart
                if (mul_done)
                begin
                    sq_sum_next = sub_reg ? (sq_sum_reg - mul_p[SQ_W-1:0]) :
                                            (sq_sum_reg + mul_p[SQ_W-1:0]);
                end
            end
            swbd_pkg::ST_MSS:
            begin
                if (mul_done)
                begin
                    ss_next = mul_p[V_W-1:0];
                end
            end
            swbd_pkg::ST_MNQ:
            begin
                if (mul_done)
                begin
                    var_next = mul_p[V_W-1:0] - ss_reg;
                end
            end
            swbd_pkg::ST_MNX:
            begin
                if (mul_done)
                begin
                    above_next = (nx_val > sum_reg);
                end
            end
            swbd_pkg::ST_MDD:
            begin
                if (mul_done)
                begin
                    lhs_next = {mul_p[V_W-1:0], {swbd_pkg::SCORE_SHIFT{1'b0}}};
                end
            end
            swbd_pkg::ST_MTS:
            begin
                if (mul_done)
                begin
                    strong_hit_next = above_reg && (P_W'(lhs_reg) > mul_p);
                end
            end
            swbd_pkg::ST_MTW:
            begin
                if (mul_done)
                begin
                    weak_hit_next = above_reg && (P_W'(lhs_reg) > mul_p);
                end
            end
            swbd_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Mean divider: one quotient bit per cycle, started with the new sum
    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        if (state_reg == swbd_pkg::ST_READ)
        begin
            div_cnt_next = DCNT_W'(SUM_W);
            div_quo_next = sum_upd;
            div_rem_next = '0;
        end
        else if (!div_done)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
            div_quo_next = {div_quo_reg[SUM_W-2:0], div_ge};
            div_rem_next = div_ge ? NB'(div_trial - (NB+1)'(WINDOW_DEPTH)) :
                                    div_trial[NB-1:0];
        end
    end

    // Result register and elapsed counters
    always_comb
    begin
        out_valid_next      = out_valid_reg;
        strong_beat_next    = strong_beat_reg;
        weak_beat_next      = weak_beat_reg;
        window_mean_next    = window_mean_reg;
        strong_elapsed_next = strong_elapsed_reg;
        weak_elapsed_next   = weak_elapsed_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next      = 1'b1;
            strong_beat_next    = strong_fire;
            weak_beat_next      = weak_fire;
            window_mean_next    = div_quo_reg[EW-1:0];
            strong_elapsed_next = strong_fire ? '0 : strong_inc;
            weak_elapsed_next   = weak_fire ? '0 : weak_inc;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= swbd_pkg::ST_IDLE;
            strong_thr_reg     <= swbd_pkg::STRONG_THR_RESET;
            weak_thr_reg       <= swbd_pkg::WEAK_THR_RESET;
            strong_cool_reg    <= swbd_pkg::STRONG_COOL_RESET;
            weak_cool_reg      <= swbd_pkg::WEAK_COOL_RESET;
            slot_reg           <= '0;
            wrapped_reg        <= 1'b0;
            sum_reg            <= '0;
            sq_sum_reg         <= '0;
            strong_elapsed_reg <= '0;
            weak_elapsed_reg   <= '0;
            div_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            strong_thr_reg     <= strong_thr_next;
            weak_thr_reg       <= weak_thr_next;
            strong_cool_reg    <= strong_cool_next;
            weak_cool_reg      <= weak_cool_next;
            slot_reg           <= slot_next;
            wrapped_reg        <= wrapped_next;
            sum_reg            <= sum_next;
            sq_sum_reg         <= sq_sum_next;
            strong_elapsed_reg <= strong_elapsed_next;
            weak_elapsed_reg   <= weak_elapsed_next;
            div_cnt_reg        <= div_cnt_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        sub_reg         <= sub_next;
        ss_reg          <= ss_next;
        var_reg         <= var_next;
        above_reg       <= above_next;
        lhs_reg         <= lhs_next;
        strong_hit_reg  <= strong_hit_next;
        weak_hit_reg    <= weak_hit_next;
        div_quo_reg     <= div_quo_next;
        div_rem_reg     <= div_rem_next;
        strong_beat_reg <= strong_beat_next;
        weak_beat_reg   <= weak_beat_next;
        window_mean_reg <= window_mean_next;
    end

    assign out_valid   = out_valid_reg;
    assign strong_beat = strong_beat_reg;
    assign weak_beat   = weak_beat_reg;
    assign window_mean = window_mean_reg;

    // A new result only appears out of the final state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == swbd_pkg::ST_DONE))
        else $error("result loaded outside the final state");

    // The window read always follows a transfer taken while idle
    a_read_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swbd_pkg::ST_READ) |-> $past(state_reg == swbd_pkg::ST_IDLE))
        else $error("window read without an input transfer");

    // The write slot stays inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("write slot beyond window depth");

    // The wrap flag stays set once the window has wrapped and every entry holds a real sample
    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag cleared outside reset");

endmodule
